FILE: rtl/cal_pkg.sv
`default_nettype none

package cal_pkg;

    // Operation codes carried in the request tuser
    typedef enum logic [2:0] {
        OP_APPEND     = 3'd0,
        OP_REMOVE_AT  = 3'd1,
        OP_REMOVE_KEY = 3'd2,
        OP_CONTAINS   = 3'd3,
        OP_INDEX_OF   = 3'd4,
        OP_GET        = 3'd5
    } t_op;

    // Result status codes carried in the result tuser
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_RANGE     = 3'd2,
        ST_FULL      = 3'd3,
        ST_ZERO      = 3'd4
    } t_status;

    localparam int unsigned POS_W    = 5;
    localparam int unsigned KEY_W    = 32;
    localparam int unsigned COUNT_W  = 6;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    capture;
        logic    append_wr;
        logic    cnt_dec;
        logic    rd_en;
        logic    rd_from_pos;
        logic    ptr_clr;
        logic    ptr_from_pos;
        logic    ptr_from_hit;
        logic    ptr_inc;
        logic    shift_wr;
        logic    set_status;
        t_status code;
        logic    set_found;
        logic    set_read;
        logic    out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        t_op  op;
        logic key_zero;
        logic list_full;
        logic pos_range;
        logic rd_vld;
        logic rd_match;
        logic scan_end;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: rtl/compacting_array_list.sv
// Channel   | Dir | tdata                                   | tuser
// ----------+-----+-----------------------------------------+-----------------
// s_axis    | in  | [4:0] position, [36:5] key, pad to 40   | [2:0] operation
// m_axis    | out | [4:0] found_position, [36:5] read_key,  | [2:0] status
//           |     | [42:37] count, pad to 48                |
//
// Sequencing: append, errors and unused codes go straight from decide to finish; get
// reads the entry store first; lookups scan from index 0 and stop at the first hit;
// removals move one entry a cycle. Reset: synchronous, active low; clears the entry
// count, the read and result valid flags and the controller state.
// Stalls: the controller holds in its finish state until the result register frees; the next
// request can be taken in the cycle after the previous result is loaded.
`default_nettype none

module compacting_array_list import cal_pkg::*; #(
    parameter int CAPACITY  = 32,
    parameter int KEY_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [39:0] i_s_axis_tdata,  // [4:0] position, [36:5] key, [39:37] zero
    input  wire logic [2:0]  i_s_axis_tuser,  // [2:0] operation
    // result channel
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [47:0]      o_m_axis_tdata,  // [4:0] found_position, [36:5] read_key,
                                              // [42:37] count, [47:43] zero
    output logic [2:0]       o_m_axis_tuser   // [2:0] status
);

    t_dp_cmd              w_cmd;
    t_dp_stat             w_stat;
    t_status              w_status;
    logic [POS_W-1:0]     w_found;
    logic [KEY_W-1:0]     w_read_key;
    logic [COUNT_W-1:0]   w_count;

    // Sequence each request: decide, scan, shift or read as the operation needs, then publish
    cal_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_stat     (w_stat),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (w_cmd)
    );

    // Entry store, count, scan pointer and result register
    cal_datapath #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (t_op'(i_s_axis_tuser)),
        .i_position  (i_s_axis_tdata[4:0]),
        .i_key       (i_s_axis_tdata[36:5]),
        .i_cmd       (w_cmd),
        .i_out_ready (i_m_axis_tready),
        .o_stat      (w_stat),
        .o_out_valid (o_m_axis_tvalid),
        .o_status    (w_status),
        .o_found     (w_found),
        .o_read_key  (w_read_key),
        .o_count     (w_count)
    );

    // Pack the result fields, lowest field first
    assign o_m_axis_tdata = {5'b0, w_count, w_read_key, w_found};
    assign o_m_axis_tuser = w_status;

endmodule

`default_nettype wire

FILE: rtl/cal_datapath.sv
`default_nettype none

module cal_datapath import cal_pkg::*; #(
    parameter int CAPACITY  = 32,
    parameter int KEY_WIDTH = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_op                 i_op,
    input  wire logic [POS_W-1:0]    i_position,
    input  wire logic [KEY_W-1:0]    i_key,
    input  wire t_dp_cmd             i_cmd,
    input  wire logic                i_out_ready,
    output t_dp_stat                 o_stat,
    output logic                     o_out_valid,
    output t_status                  o_status,
    output logic [POS_W-1:0]         o_found,
    output logic [KEY_W-1:0]         o_read_key,
    output logic [COUNT_W-1:0]       o_count
);

    localparam int KW = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

    logic [KW-1:0]      r_mem [CAPACITY];

    t_op                r_op;
    logic [POS_W-1:0]   r_pos;
    logic [KW-1:0]      r_key;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_ptr;
    logic               r_rd_vld;
    logic [AW-1:0]      r_rd_addr;
    logic [KW-1:0]      r_rdata;
    t_status            r_status;
    logic [POS_W-1:0]   r_found;
    logic [KEY_W-1:0]   r_rkey;
    logic               r_out_valid;
    t_status            r_o_status;
    logic [POS_W-1:0]   r_o_found;
    logic [KEY_W-1:0]   r_o_rkey;
    logic [COUNT_W-1:0] r_o_count;

    logic [AW-1:0]      w_rd_addr;

    assign w_rd_addr = i_cmd.rd_from_pos ? AW'(r_pos) : r_ptr[AW-1:0];

    // Entry store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.append_wr) begin
            r_mem[r_count[AW-1:0]] <= r_key;
        end else if (i_cmd.shift_wr) begin
            r_mem[r_rd_addr - AW'(1)] <= r_rdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata   <= r_mem[w_rd_addr];
            r_rd_addr <= w_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
            if (i_cmd.append_wr) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_op;
            r_pos    <= i_position;
            r_key    <= KW'(i_key);
            r_status <= ST_OK;
            r_found  <= '0;
            r_rkey   <= '0;
        end else begin
            if (i_cmd.set_status) begin
                r_status <= i_cmd.code;
            end
            if (i_cmd.set_found) begin
                r_found <= POS_W'(r_rd_addr);
            end
            if (i_cmd.set_read) begin
                r_rkey <= KEY_W'(r_rdata);
            end
        end

        if (i_cmd.ptr_clr) begin
            r_ptr <= '0;
        end else if (i_cmd.ptr_from_pos) begin
            r_ptr <= CW'(XW'(r_pos) + XW'(1));
        end else if (i_cmd.ptr_from_hit) begin
            r_ptr <= CW'(r_rd_addr) + CW'(1);
        end else if (i_cmd.ptr_inc) begin
            r_ptr <= r_ptr + CW'(1);
        end

        if (i_cmd.out_load) begin
            r_o_status <= r_status;
            r_o_found  <= r_found;
            r_o_rkey   <= r_rkey;
            r_o_count  <= COUNT_W'(r_count);
        end
    end

    always_comb begin
        o_stat.op        = r_op;
        o_stat.key_zero  = (r_key == '0);
        o_stat.list_full = (r_count == CW'(CAPACITY));
        o_stat.pos_range = (XW'(r_pos) >= XW'(r_count));
        o_stat.rd_vld    = r_rd_vld;
        o_stat.rd_match  = (r_rdata == r_key);
        o_stat.scan_end  = (r_ptr == r_count);
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_o_status;
    assign o_found     = r_o_found;
    assign o_read_key  = r_o_rkey;
    assign o_count     = r_o_count;

endmodule

`default_nettype wire

FILE: rtl/cal_ctrl.sv
`default_nettype none

module cal_ctrl import cal_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire t_dp_stat i_stat,
    output logic          o_in_ready,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_SHIFT,
        S_GET_WAIT,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_uses_key;

    assign w_uses_key = (i_stat.op == OP_APPEND) || (i_stat.op == OP_REMOVE_KEY) ||
                        (i_stat.op == OP_CONTAINS) || (i_stat.op == OP_INDEX_OF);

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.code = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (w_uses_key && i_stat.key_zero) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.code       = ST_ZERO;
                    n_state          = S_FINISH;
                end else begin
                    unique case (i_stat.op)
                        OP_APPEND: begin
                            if (i_stat.list_full) begin
                                o_cmd.set_status = 1'b1;
                                o_cmd.code       = ST_FULL;
                            end else begin
                                o_cmd.append_wr = 1'b1;
                            end
                            n_state = S_FINISH;
                        end
                        OP_REMOVE_AT: begin
                            if (i_stat.pos_range) begin
                                o_cmd.set_status = 1'b1;
                                o_cmd.code       = ST_RANGE;
                                n_state          = S_FINISH;
                            end else begin
                                o_cmd.ptr_from_pos = 1'b1;
                                n_state            = S_SHIFT;
                            end
                        end
                        OP_REMOVE_KEY, OP_CONTAINS, OP_INDEX_OF: begin
                            o_cmd.ptr_clr = 1'b1;
                            n_state       = S_SCAN;
                        end
                        OP_GET: begin
                            if (i_stat.pos_range) begin
                                o_cmd.set_status = 1'b1;
                                o_cmd.code       = ST_RANGE;
                                n_state          = S_FINISH;
                            end else begin
                                o_cmd.rd_en       = 1'b1;
                                o_cmd.rd_from_pos = 1'b1;
                                n_state           = S_GET_WAIT;
                            end
                        end
                        default: begin
                            n_state = S_FINISH;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                priority if (i_stat.rd_vld && i_stat.rd_match) begin
                    o_cmd.set_found = (i_stat.op != OP_CONTAINS);
                    if (i_stat.op == OP_REMOVE_KEY) begin
                        o_cmd.ptr_from_hit = 1'b1;
                        n_state            = S_SHIFT;
                    end else begin
                        n_state = S_FINISH;
                    end
                end else if (!i_stat.scan_end) begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.ptr_inc = 1'b1;
                end else if (!i_stat.rd_vld) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.code       = ST_NOT_FOUND;
                    n_state          = S_FINISH;
                end else begin
                    // hold: the last read missed; wait for the read valid flag to clear
                    n_state = S_SCAN;
                end
            end
            S_SHIFT: begin
                o_cmd.shift_wr = i_stat.rd_vld;
                if (!i_stat.scan_end) begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.ptr_inc = 1'b1;
                end else if (!i_stat.rd_vld) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_FINISH;
                end
            end
            S_GET_WAIT: begin
                o_cmd.set_read = 1'b1;
                n_state        = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire
